// File: sv/ptm_pkg.sv
// shared types and constants for the two-level page table manager
`default_nettype none
package ptm_pkg;

  localparam int unsigned IDX_W    = 10;
  localparam int unsigned OFS_W    = 12;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned DIR_SIZE = 1024;
  localparam int unsigned TBL_SIZE = 1024;

  // request codes on the input side
  localparam logic [1:0] REQ_MAP   = 2'd0;
  localparam logic [1:0] REQ_UNMAP = 2'd1;
  localparam logic [1:0] REQ_XLATE = 2'd2;

  localparam logic [OFS_W-1:0] ID_FLAGS = 12'h003;

  // request queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = 1;

  typedef enum logic [1:0] {
    K_MAP,
    K_UNMAP,
    K_XLATE,
    K_NONE
  } ptm_kind_t;

  typedef struct packed {
    ptm_kind_t               kind;
    logic [IDX_W-1:0]        dir_idx;
    logic [IDX_W-1:0]        tbl_idx;
    logic [OFS_W-1:0]        offset;
    logic [WORD_W-1:0]       wdata;
  } ptm_cmd_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } ptm_back_status_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOOK,
    BK_READ
  } ptm_state_t;

endpackage
`default_nettype wire

// File: sv/ptm_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module ptm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/ptm_front.sv
// request intake: decode and two-entry queue toward the walker
`default_nettype none
module ptm_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [79:0]              in_tdata,
  input  wire logic [1:0]               in_tuser,
  input  wire ptm_pkg::ptm_back_status_t status,
  output logic                          head_valid,
  output ptm_pkg::ptm_cmd_t             head
);

  ptm_pkg::ptm_cmd_t            q_r [ptm_pkg::Q_DEPTH];
  logic [ptm_pkg::Q_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [ptm_pkg::Q_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [ptm_pkg::Q_AW:0]       cnt_r, cnt_nxt;
  ptm_pkg::ptm_cmd_t            cmd;
  ptm_pkg::ptm_kind_t           kind;
  logic                         push;
  logic                         pop;

  always_comb begin
    case (in_tuser)
      ptm_pkg::REQ_MAP:   kind = ptm_pkg::K_MAP;
      ptm_pkg::REQ_UNMAP: kind = ptm_pkg::K_UNMAP;
      ptm_pkg::REQ_XLATE: kind = ptm_pkg::K_XLATE;
      default:            kind = ptm_pkg::K_NONE;
    endcase
  end

  always_comb begin
    cmd.kind    = kind;
    cmd.dir_idx = in_tdata[31:22];
    cmd.tbl_idx = in_tdata[21:12];
    cmd.offset  = in_tdata[11:0];
    // frame from the physical address, flags from the flag field
    cmd.wdata   = {in_tdata[63:44], in_tdata[75:64]};
  end

  assign in_tready  = (cnt_r != (ptm_pkg::Q_AW+1)'(ptm_pkg::Q_DEPTH)) && !status.clearing;
  assign push       = in_tvalid && in_tready;
  assign pop        = status.pop;
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

endmodule
`default_nettype wire

// File: sv/ptm_back.sv
// table walker: directory and table memories, allocation, clear pass, result register
`default_nettype none
module ptm_back #(
  parameter int unsigned NUM_TABLES = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      head_valid,
  input  wire ptm_pkg::ptm_cmd_t         head,
  output ptm_pkg::ptm_back_status_t      status,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [71:0]                    out_tdata
);

  localparam int unsigned TAB_W       = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int unsigned NFT_W       = $clog2(NUM_TABLES + 1);
  localparam int unsigned DIR_W       = TAB_W + 1;
  localparam int unsigned STORE_DEPTH = NUM_TABLES * ptm_pkg::TBL_SIZE;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);
  localparam int unsigned DIR_AW      = $clog2(ptm_pkg::DIR_SIZE);

  ptm_pkg::ptm_state_t        state_r, state_nxt;
  ptm_pkg::ptm_cmd_t          cur_r;
  logic [STORE_AW-1:0]        clr_r, clr_nxt;
  logic [NFT_W-1:0]           nft_r, nft_nxt;
  logic [31:0]                cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       ok_r;
  logic [31:0]                phys_r;
  logic [31:0]                flush_r;

  logic                       dir_we;
  logic [DIR_AW-1:0]          dir_waddr, dir_raddr;
  logic [DIR_W-1:0]           dir_wdata, dir_rdata;
  logic                       st_we;
  logic [STORE_AW-1:0]        st_waddr, st_raddr;
  logic [31:0]                st_wdata, st_rdata;

  logic                       start;
  logic                       clr_last;
  logic                       dir_hit;
  logic [TAB_W-1:0]           dir_tab;
  logic                       pool_ok;
  logic [TAB_W-1:0]           new_tab;
  logic                       res_load;
  logic                       res_ok;
  logic [31:0]                res_phys;
  logic                       cnt_inc;
  logic                       nft_inc;

  assign start    = head_valid && (!out_valid_r || out_tready);
  assign clr_last = (clr_r == STORE_AW'(STORE_DEPTH - 1));
  assign dir_hit  = dir_rdata[TAB_W];
  assign dir_tab  = dir_rdata[TAB_W-1:0];
  assign pool_ok  = (nft_r < NFT_W'(NUM_TABLES));
  assign new_tab  = TAB_W'(nft_r);

  assign status = '{clearing: (state_r == ptm_pkg::BK_CLEAR),
                    pop:      ((state_r == ptm_pkg::BK_IDLE) && start)};

  ptm_ram #(.WIDTH(DIR_W), .DEPTH(ptm_pkg::DIR_SIZE)) u_dir (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  ptm_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptm_pkg::BK_CLEAR: begin
        if (clr_last) begin
          state_nxt = ptm_pkg::BK_IDLE;
        end
      end
      ptm_pkg::BK_IDLE: begin
        if (start) begin
          state_nxt = ptm_pkg::BK_LOOK;
        end
      end
      ptm_pkg::BK_LOOK: begin
        if (cur_r.kind == ptm_pkg::K_XLATE && dir_hit) begin
          state_nxt = ptm_pkg::BK_READ;
        end else begin
          state_nxt = ptm_pkg::BK_IDLE;
        end
      end
      ptm_pkg::BK_READ: state_nxt = ptm_pkg::BK_IDLE;
      default:          state_nxt = ptm_pkg::BK_IDLE;
    endcase
  end

  // outputs of each state
  always_comb begin
    dir_we    = 1'b0;
    dir_waddr = clr_r[DIR_AW-1:0];
    dir_wdata = '0;
    dir_raddr = head.dir_idx;
    st_we     = 1'b0;
    st_waddr  = clr_r;
    st_wdata  = '0;
    st_raddr  = STORE_AW'({dir_tab, cur_r.tbl_idx});
    res_load  = 1'b0;
    res_ok    = 1'b0;
    res_phys  = '0;
    cnt_inc   = 1'b0;
    nft_inc   = 1'b0;
    case (state_r)
      ptm_pkg::BK_CLEAR: begin
        // table 0 gets the identity map of the first 4MB, all else zero
        st_we = 1'b1;
        if (32'(clr_r) < ptm_pkg::TBL_SIZE) begin
          st_wdata = 32'({clr_r[9:0], ptm_pkg::ID_FLAGS});
          dir_we   = 1'b1;
          if (clr_r == '0) begin
            dir_wdata = {1'b1, {TAB_W{1'b0}}};
          end
        end
      end
      ptm_pkg::BK_IDLE: begin
      end
      ptm_pkg::BK_LOOK: begin
        case (cur_r.kind)
          ptm_pkg::K_MAP: begin
            res_load = 1'b1;
            st_wdata = cur_r.wdata;
            if (dir_hit) begin
              st_we    = 1'b1;
              st_waddr = STORE_AW'({dir_tab, cur_r.tbl_idx});
              res_ok   = 1'b1;
              cnt_inc  = 1'b1;
            end else if (pool_ok) begin
              // fresh tables are already zero from the reset pass
              dir_we    = 1'b1;
              dir_waddr = cur_r.dir_idx;
              dir_wdata = {1'b1, new_tab};
              st_we     = 1'b1;
              st_waddr  = STORE_AW'({new_tab, cur_r.tbl_idx});
              res_ok    = 1'b1;
              cnt_inc   = 1'b1;
              nft_inc   = 1'b1;
            end
          end
          ptm_pkg::K_UNMAP: begin
            res_load = 1'b1;
            if (dir_hit) begin
              st_we    = 1'b1;
              st_waddr = STORE_AW'({dir_tab, cur_r.tbl_idx});
              res_ok   = 1'b1;
              cnt_inc  = 1'b1;
            end
          end
          ptm_pkg::K_XLATE: begin
            res_load = !dir_hit;
          end
          default: begin
            res_load = 1'b1;
          end
        endcase
      end
      ptm_pkg::BK_READ: begin
        res_load = 1'b1;
        if (st_rdata[0]) begin
          res_ok   = 1'b1;
          res_phys = {st_rdata[31:12], cur_r.offset};
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    clr_nxt       = (state_r == ptm_pkg::BK_CLEAR) ? clr_r + 1'b1 : clr_r;
    nft_nxt       = nft_inc ? nft_r + 1'b1 : nft_r;
    cnt_nxt       = cnt_inc ? cnt_r + 32'd1 : cnt_r;
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptm_pkg::BK_CLEAR;
      clr_r       <= '0;
      nft_r       <= NFT_W'(1);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      nft_r       <= nft_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (status.pop) begin
      cur_r <= head;
    end
    if (res_load) begin
      ok_r    <= res_ok;
      phys_r  <= res_phys;
      flush_r <= cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, flush_r, phys_r, ok_r};

endmodule
`default_nettype wire

// File: sv/two_level_page_table_manager.sv
// top level of the two-level page table manager: request front and table walker
// results: map, unmap and translates that miss the directory finish after the directory lookup;
// translates that walk both levels also wait for the dependent page table read
// the walker takes one request at a time and takes the next only after the directory read and,
// for a full translate walk, the page table read; it also waits while a result waits on out_tready
// reset: a clear pass writes all table store and directory entries, in_tready low till then
`default_nettype none
module two_level_page_table_manager #(
  parameter int unsigned NUM_TABLES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // virtual address, physical address, flags, zero pad
  input  wire logic [1:0]  in_tuser,   // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata   // ok, phys_result, flush_count, zero pad
);

  ptm_pkg::ptm_back_status_t status;
  ptm_pkg::ptm_cmd_t         head;
  logic                      head_valid;

  ptm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .status     (status),
    .head_valid (head_valid),
    .head       (head)
  );

  ptm_back #(.NUM_TABLES(NUM_TABLES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// File: test/page_walk_checker.sv
// checker for the page table manager: predicts each result from the input transfers and compares
module page_walk_checker #(
  parameter int unsigned NUM_TABLES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,    // virtual address, physical address, flags, zero pad
  input  logic [1:0]  in_tuser,    // req_type
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,   // ok, phys_result, flush_count, zero pad
  output int unsigned backlog,
  output int unsigned fail_count
);

  typedef struct packed {
    logic                       ok;
    logic [ptm_pkg::WORD_W-1:0] phys;
    logic [ptm_pkg::WORD_W-1:0] flushes;
  } walk_res_t;

  walk_res_t                  expected_walks[$];
  logic                       dir_present[ptm_pkg::DIR_SIZE];
  int unsigned                dir_table[ptm_pkg::DIR_SIZE];
  logic [ptm_pkg::WORD_W-1:0] pte_mem[NUM_TABLES*ptm_pkg::TBL_SIZE];
  int unsigned                tables_taken;
  logic [ptm_pkg::WORD_W-1:0] flush_total;
  int unsigned                mismatch_count = 0;

  assign fail_count = mismatch_count;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (mismatch_count < 100)
      $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
    mismatch_count++;
  endtask

  // one request against the shadow directory and table store
  task automatic walk_request(input logic [1:0] req, input logic [31:0] va,
                              input logic [31:0] pa, input logic [ptm_pkg::OFS_W-1:0] fl,
                              output walk_res_t res);
    logic [ptm_pkg::IDX_W-1:0]  di;
    logic [ptm_pkg::IDX_W-1:0]  ti;
    logic                       hit;
    int unsigned                slot;
    logic [ptm_pkg::WORD_W-1:0] pte;
    di  = va[31:22];
    ti  = va[21:12];
    res = '0;
    hit = dir_present[di];
    case (req)
      ptm_pkg::REQ_MAP: begin
        // new directory entry takes a fresh table while the pool lasts
        if (!hit && tables_taken < NUM_TABLES) begin
          for (int i = 0; i < ptm_pkg::TBL_SIZE; i++)
            pte_mem[tables_taken*ptm_pkg::TBL_SIZE + i] = '0;
          dir_table[di]   = tables_taken;
          dir_present[di] = 1'b1;
          tables_taken++;
          hit = 1'b1;
        end
        if (hit) begin
          slot          = dir_table[di] * ptm_pkg::TBL_SIZE + ti;
          pte_mem[slot] = {pa[31:12], fl};
          flush_total++;
          res.ok = 1'b1;
        end
      end
      ptm_pkg::REQ_UNMAP: begin
        if (hit) begin
          slot          = dir_table[di] * ptm_pkg::TBL_SIZE + ti;
          pte_mem[slot] = '0;
          flush_total++;
          res.ok = 1'b1;
        end
      end
      ptm_pkg::REQ_XLATE: begin
        if (hit) begin
          slot = dir_table[di] * ptm_pkg::TBL_SIZE + ti;
          pte  = pte_mem[slot];
          if (pte[0]) begin
            res.ok   = 1'b1;
            res.phys = {pte[31:12], va[11:0]};
          end
        end
      end
      default: begin
      end
    endcase
    res.flushes = flush_total;
  endtask

  always @(posedge clk) begin : watch_channels
    walk_res_t want;
    walk_res_t got;
    if (!rst_n) begin
      for (int i = 0; i < ptm_pkg::DIR_SIZE; i++) begin
        dir_present[i] = 1'b0;
        dir_table[i]   = 0;
      end
      // table 0 identity maps the first 4MB
      for (int i = 0; i < NUM_TABLES*ptm_pkg::TBL_SIZE; i++)
        pte_mem[i] = (i < ptm_pkg::TBL_SIZE) ? ((i << ptm_pkg::OFS_W) | ptm_pkg::ID_FLAGS)
                                             : '0;
      dir_present[0] = 1'b1;
      tables_taken   = 1;
      flush_total    = '0;
      expected_walks.delete();
    end else begin
      // result side first: a result never belongs to a request taken at the same edge
      if (out_tvalid && out_tready) begin
        got = {out_tdata[0], out_tdata[32:1], out_tdata[64:33]};
        if (expected_walks.size() == 0) begin
          report_mismatch("unexpected transfer", '0, got.phys);
        end else begin
          want = expected_walks.pop_front();
          if (got.ok !== want.ok)
            report_mismatch("ok", want.ok, got.ok);
          if (got.phys !== want.phys)
            report_mismatch("phys_result", want.phys, got.phys);
          if (got.flushes !== want.flushes)
            report_mismatch("flush_count", want.flushes, got.flushes);
        end
      end
      if (in_tvalid && in_tready) begin
        walk_request(in_tuser, in_tdata[31:0], in_tdata[63:32], in_tdata[75:64], want);
        expected_walks.push_back(want);
      end
    end
    backlog <= expected_walks.size();
  end

endmodule

// File: test/tb_top.sv
// top of the page table manager regression: stimulus, flow control and verdict
module tb_top;

  localparam int unsigned NUM_TABLES   = 16;
  localparam logic [1:0]  REQ_UNKNOWN  = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned STALL_LIMIT  = 60000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned POOL_SIZE    = 20;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;

  int unsigned backlog;
  int unsigned fail_count;
  int unsigned send_cap;
  int unsigned recv_cap;
  int unsigned quiet_cycles = 0;
  logic [ptm_pkg::IDX_W-1:0] dir_pool[POOL_SIZE];

  two_level_page_table_manager #(
    .NUM_TABLES(NUM_TABLES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  page_walk_checker #(
    .NUM_TABLES(NUM_TABLES)
  ) chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .backlog   (backlog),
    .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // cycles without any transfer; also covers the clearing pass after reset
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [1:0] req, input logic [31:0] va,
                              input logic [31:0] pa, input logic [ptm_pkg::OFS_W-1:0] fl);
    int unsigned gap;
    gap = $urandom_range(0, send_cap);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {4'b0, fl, pa, va};
    do @(posedge clk); while (!in_tready);
  endtask

  // result side: random stalls per transfer, one long hold to back up the block
  initial begin : receiver
    int unsigned taken;
    int unsigned gap;
    taken = 0;
    wait (rst_n === 1'b1);
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        taken++;
        if (taken % 64 == 0)
          recv_cap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 19);
        gap = (taken == 250) ? LONG_HOLD : $urandom_range(0, recv_cap);
        if (gap != 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    logic [1:0]                req;
    logic [ptm_pkg::IDX_W-1:0] di;
    logic [ptm_pkg::IDX_W-1:0] ti;
    logic [ptm_pkg::OFS_W-1:0] fl;
    int unsigned               pick;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    send_cap   = 0;
    recv_cap   = 4;
    // a few more directory slots than the pool has tables, so the pool runs dry
    for (int i = 0; i < POOL_SIZE; i++)
      dir_pool[i] = (i == 0) ? '0 : (i == 1) ? '1 :
                    (i == 2) ? ptm_pkg::IDX_W'(1) : ptm_pkg::IDX_W'($urandom);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // identity region, absent directory, fresh tables, entries without present flag
    send_request(ptm_pkg::REQ_XLATE, 32'h0000_0000, 32'h0, 12'h000);
    send_request(ptm_pkg::REQ_XLATE, 32'h003F_FFFF, 32'h0, 12'h000);
    send_request(ptm_pkg::REQ_XLATE, 32'hFFFF_FFFF, 32'h0, 12'h000);
    send_request(ptm_pkg::REQ_UNMAP, 32'hFFC0_0000, 32'h0, 12'h000);
    send_request(ptm_pkg::REQ_MAP,   32'hFFFF_F123, 32'hFFFF_FFFF, 12'hFFF);
    send_request(ptm_pkg::REQ_XLATE, 32'hFFFF_FABC, 32'h0, 12'h000);
    send_request(ptm_pkg::REQ_MAP,   32'h0040_0000, 32'h0000_0000, 12'h000);
    send_request(ptm_pkg::REQ_XLATE, 32'h0040_0000, 32'h0, 12'h000);
    send_request(ptm_pkg::REQ_UNMAP, 32'h0000_1000, 32'h0, 12'h000);
    send_request(ptm_pkg::REQ_XLATE, 32'h0000_1234, 32'h0, 12'h000);
    send_request(ptm_pkg::REQ_UNMAP, 32'h0000_1000, 32'h0, 12'h000);
    send_request(REQ_UNKNOWN,        32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    send_request(ptm_pkg::REQ_MAP,   32'h0000_2000, 32'hABCD_E000, 12'h001);
    send_request(ptm_pkg::REQ_XLATE, 32'h0000_2FFF, 32'h0, 12'h000);
    send_request(ptm_pkg::REQ_MAP,   32'h8000_0000, 32'h1234_5678, 12'h555);
    send_request(ptm_pkg::REQ_UNMAP, 32'hFFFF_F000, 32'h0, 12'h000);
    send_request(ptm_pkg::REQ_XLATE, 32'hFFFF_F000, 32'h0, 12'h000);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0)
        send_cap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 19);
      // drain completely once in the middle of the run
      if (n == 900) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (backlog != 0);
      end
      pick = $urandom_range(0, 99);
      req  = (pick < 40) ? ptm_pkg::REQ_MAP : (pick < 55) ? ptm_pkg::REQ_UNMAP :
             (pick < 96) ? ptm_pkg::REQ_XLATE : REQ_UNKNOWN;
      // mostly a small set of pages so translates and unmaps hit earlier maps
      di = ($urandom_range(0, 6) == 0) ? ptm_pkg::IDX_W'($urandom)
                                       : dir_pool[$urandom_range(0, POOL_SIZE-1)];
      ti = ($urandom_range(0, 3) == 0) ? ptm_pkg::IDX_W'($urandom)
                                       : ptm_pkg::IDX_W'($urandom_range(0, 15));
      fl = ptm_pkg::OFS_W'($urandom);
      if ($urandom_range(0, 4) != 0)
        fl[0] = 1'b1;
      send_request(req, {di, ti, ptm_pkg::OFS_W'($urandom)}, $urandom, fl);
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && backlog == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
sv/ptm_pkg.sv
sv/ptm_ram.sv
sv/ptm_front.sv
sv/ptm_back.sv
sv/two_level_page_table_manager.sv
test/page_walk_checker.sv
test/tb_top.sv
